>>> hdl/idsg_pkg.sv
// ----------------------------------------------------------------------------
// idsg_pkg
// Types and constants shared by the indirect descriptor scatter-gather walker.
// ----------------------------------------------------------------------------
package idsg_pkg;

  localparam int unsigned LOCAL_DEPTH_DEF = 16;
  localparam int unsigned DESC_BYTES      = 16;
  // one local descriptor in the store: {address, length}
  localparam int unsigned DESC_W          = 96;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_XFER  = 2'd2,
    REQ_FETCH = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    RES_SEG       = 3'd0,
    RES_FETCH     = 3'd1,
    RES_DONE      = 3'd2,
    RES_NO_DESC   = 3'd3,
    RES_FETCH_ERR = 3'd4
  } result_kind_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [63:0] address;
    logic [31:0] length;
    logic [15:0] total_count;
    logic [4:0]  local_count;
    logic        to_device;
    logic        fetch_failed;
  } req_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [63:0]  seg_address;
    logic [31:0]  seg_length;
    logic         direction;
    logic [31:0]  buffer_offset;
    logic [31:0]  bytes_done;
    logic         last;
  } res_t;

endpackage

>>> hdl/idsg_ram.sv
// ----------------------------------------------------------------------------
// idsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/indirect_descriptor_sg_walker_core.sv
// ----------------------------------------------------------------------------
// indirect_descriptor_sg_walker_core
// Walks local and external descriptors, splitting a transfer into segments.
// ----------------------------------------------------------------------------
// Steps: start, load and fetch-error items are handled in the idle state; a
//   transfer or a good fetch walks, forming one result per segment, taking each
//   local descriptor by a store read in ST_WALK and a load in ST_LOAD, and ending with a closing result.
// Results leave a register in the cycle after they are formed, at most one per cycle.
// Throughput: one item at a time; busy stays high while the walk runs.
// Reset clears all control state; the local store is undefined until loaded.
module indirect_descriptor_sg_walker_core #(
  parameter int unsigned LOCAL_DEPTH = idsg_pkg::LOCAL_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  idsg_pkg::req_t item_i,
  output logic          res_strobe_o,
  output idsg_pkg::res_t res_o
);
  import idsg_pkg::*;

  localparam int unsigned IDX_W = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LOCAL_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD
  } state_e;

  state_e      state_q, state_d;
  logic [CNT_W-1:0] load_idx_q, load_idx_d;
  logic [CNT_W-1:0] cur_idx_q, cur_idx_d;
  logic [CNT_W-1:0] locals_q, locals_d;
  logic        cur_valid_q, cur_valid_d;
  logic [63:0] cur_addr_q, cur_addr_d;
  logic [31:0] cur_rem_q, cur_rem_d;
  logic [63:0] table_addr_q, table_addr_d;
  logic [15:0] totals_q, totals_d;
  logic        wdir_q, wdir_d;
  logic [31:0] pending_q, pending_d;
  logic [31:0] moved_q, moved_d;
  logic        awaiting_q, awaiting_d;
  logic        strobe_q, strobe_d;
  res_t        res_q, res_d;

  logic              accept;
  logic              ram_we;
  logic [DESC_W-1:0] ram_rdata;
  logic [31:0]       piece;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign piece  = (pending_q < cur_rem_q) ? pending_q : cur_rem_q;
  assign ram_we = accept && (item_i.req_type == REQ_LOAD)
                  && (32'(load_idx_q) < 32'(LOCAL_DEPTH));

  idsg_ram #(
    .WIDTH (DESC_W),
    .DEPTH (LOCAL_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_idx_q[IDX_W-1:0]),
    .wdata_i ({item_i.address, item_i.length}),
    .raddr_i (cur_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    load_idx_d   = load_idx_q;
    cur_idx_d    = cur_idx_q;
    locals_d     = locals_q;
    cur_valid_d  = cur_valid_q;
    cur_addr_d   = cur_addr_q;
    cur_rem_d    = cur_rem_q;
    table_addr_d = table_addr_q;
    totals_d     = totals_q;
    wdir_d       = wdir_q;
    pending_d    = pending_q;
    moved_d      = moved_q;
    awaiting_d   = awaiting_q;
    strobe_d     = 1'b0;
    res_d        = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_i.req_type)
            REQ_START: begin
              table_addr_d = item_i.address;
              totals_d     = item_i.total_count;
              if (32'(item_i.local_count) > 32'(LOCAL_DEPTH)) begin
                locals_d = CNT_W'(LOCAL_DEPTH);
              end else begin
                locals_d = CNT_W'(item_i.local_count);
              end
              wdir_d      = item_i.to_device;
              load_idx_d  = '0;
              cur_idx_d   = '0;
              cur_valid_d = 1'b0;
              cur_addr_d  = '0;
              cur_rem_d   = '0;
              pending_d   = '0;
              moved_d     = '0;
              awaiting_d  = 1'b0;
            end
            REQ_LOAD: begin
              if (ram_we) begin
                load_idx_d = load_idx_q + CNT_W'(1);
              end
            end
            REQ_XFER: begin
              if (!awaiting_q) begin
                pending_d = item_i.length;
                moved_d   = '0;
                state_d   = ST_WALK;
              end
            end
            REQ_FETCH: begin
              if (awaiting_q) begin
                awaiting_d   = 1'b0;
                table_addr_d = table_addr_q + 64'(DESC_BYTES);
                totals_d     = (totals_q != 16'd0) ? totals_q - 16'd1 : 16'd0;
                if (item_i.fetch_failed) begin
                  pending_d         = '0;
                  cur_valid_d       = 1'b0;
                  strobe_d          = 1'b1;
                  res_d.result_kind = RES_FETCH_ERR;
                  res_d.direction   = wdir_q;
                  res_d.bytes_done  = moved_q;
                  res_d.last        = 1'b1;
                end else begin
                  cur_addr_d  = item_i.address;
                  cur_rem_d   = item_i.length;
                  cur_valid_d = 1'b1;
                  state_d     = ST_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        priority if (pending_q == 32'd0) begin
          strobe_d          = 1'b1;
          res_d.result_kind = RES_DONE;
          res_d.direction   = wdir_q;
          res_d.bytes_done  = moved_q;
          res_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end else if (cur_valid_q && (cur_rem_q != 32'd0)) begin
          strobe_d            = 1'b1;
          res_d.result_kind   = RES_SEG;
          res_d.seg_address   = cur_addr_q;
          res_d.seg_length    = piece;
          res_d.direction     = wdir_q;
          res_d.buffer_offset = moved_q;
          res_d.bytes_done    = moved_q + piece;
          moved_d             = moved_q + piece;
          cur_addr_d          = cur_addr_q + 64'(piece);
          cur_rem_d           = cur_rem_q - piece;
          pending_d           = pending_q - piece;
        end else if (locals_q != '0) begin
          // store read is issued at cur_idx_q this edge; data lands in ST_LOAD
          cur_valid_d  = 1'b0;
          cur_idx_d    = cur_idx_q + CNT_W'(1);
          locals_d     = locals_q - CNT_W'(1);
          table_addr_d = table_addr_q + 64'(DESC_BYTES);
          totals_d     = (totals_q != 16'd0) ? totals_q - 16'd1 : 16'd0;
          state_d      = ST_LOAD;
        end else if (totals_q == 16'd0) begin
          cur_valid_d       = 1'b0;
          pending_d         = '0;
          strobe_d          = 1'b1;
          res_d.result_kind = RES_NO_DESC;
          res_d.direction   = wdir_q;
          res_d.bytes_done  = moved_q;
          res_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cur_valid_d       = 1'b0;
          awaiting_d        = 1'b1;
          strobe_d          = 1'b1;
          res_d.result_kind = RES_FETCH;
          res_d.seg_address = table_addr_q;
          res_d.seg_length  = 32'(DESC_BYTES);
          res_d.direction   = 1'b1;
          res_d.bytes_done  = moved_q;
          res_d.last        = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      ST_LOAD: begin
        cur_addr_d  = ram_rdata[DESC_W-1:32];
        cur_rem_d   = ram_rdata[31:0];
        cur_valid_d = 1'b1;
        state_d     = ST_WALK;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      load_idx_q   <= '0;
      cur_idx_q    <= '0;
      locals_q     <= '0;
      cur_valid_q  <= 1'b0;
      cur_addr_q   <= '0;
      cur_rem_q    <= '0;
      table_addr_q <= '0;
      totals_q     <= '0;
      wdir_q       <= 1'b0;
      pending_q    <= '0;
      moved_q      <= '0;
      awaiting_q   <= 1'b0;
      strobe_q     <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q      <= state_d;
      load_idx_q   <= load_idx_d;
      cur_idx_q    <= cur_idx_d;
      locals_q     <= locals_d;
      cur_valid_q  <= cur_valid_d;
      cur_addr_q   <= cur_addr_d;
      cur_rem_q    <= cur_rem_d;
      table_addr_q <= table_addr_d;
      totals_q     <= totals_d;
      wdir_q       <= wdir_d;
      pending_q    <= pending_d;
      moved_q      <= moved_d;
      awaiting_q   <= awaiting_d;
      strobe_q     <= strobe_d;
      res_q        <= res_d;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  // a segment is never the final result, so the walk must still be running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> busy)
    else $error("segment result with walker idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> state_q == ST_IDLE)
    else $error("walking while a descriptor fetch is outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.result_kind == RES_SEG |-> res_o.seg_length != 32'd0)
    else $error("zero-length segment emitted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(locals_q) + 32'(cur_idx_q) <= 32'(LOCAL_DEPTH))
    else $error("local descriptor index beyond store depth");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indirect descriptor scatter-gather walker.
// Requests go out through a queue-fed driver, and a behavioral walk
// computes the expected segment, fetch and completion results. Each result
// strobe is checked field by field against the oldest one expected.
// ----------------------------------------------------------------------------
module testbench;
  import idsg_pkg::*;

  localparam int unsigned LOCAL_DEPTH = LOCAL_DEPTH_DEF;
  localparam int unsigned IDX_W       = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_COUNT  = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_drv = '0;
  logic res_strobe_o;
  res_t res_o;

  indirect_descriptor_sg_walker_core #(.LOCAL_DEPTH(LOCAL_DEPTH)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (req_drv),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  req_t request_q[$];
  res_t walk_results_q[$];
  logic took_item = 1'b0;
  int idle_pct = 0;
  int fail_count = 0;
  int unsigned served_items = 0;
  int unsigned quiet_cycles = 0;

  // walker state as seen from outside
  logic [63:0] desc_addr [LOCAL_DEPTH];
  logic [31:0] desc_len [LOCAL_DEPTH];
  logic [4:0]  load_idx = '0;
  logic [4:0]  cur_index = '0;
  logic        cur_valid = 1'b0;
  logic [63:0] cur_addr = '0;
  logic [31:0] cur_remaining = '0;
  logic [63:0] tbl_addr = '0;
  logic [4:0]  loc_left = '0;
  logic [15:0] tot_left = '0;
  logic        write_dir = 1'b0;
  logic [31:0] pending_bytes = '0;
  logic [31:0] moved_bytes = '0;
  logic        awaiting_fetch = 1'b0;

  function automatic void push_result(result_kind_e kind, logic [63:0] addr,
                                      logic [31:0] len, logic dir, logic [31:0] off,
                                      logic last);
    res_t r;
    r.result_kind   = kind;
    r.seg_address   = addr;
    r.seg_length    = len;
    r.direction     = dir;
    r.buffer_offset = off;
    r.bytes_done    = moved_bytes;
    r.last          = last;
    walk_results_q.push_back(r);
  endfunction

  function automatic void consume_table_entry();
    tbl_addr = tbl_addr + 64'(DESC_BYTES);
    if (tot_left != 16'd0) tot_left = tot_left - 16'd1;
  endfunction

  function automatic void walk_pending();
    logic [31:0] piece;
    logic [31:0] off;
    while (pending_bytes != 0) begin
      if (cur_valid && cur_remaining == 0) cur_valid = 1'b0;
      if (!cur_valid) begin
        if (loc_left != 0) begin
          cur_addr      = desc_addr[cur_index[IDX_W-1:0]];
          cur_remaining = desc_len[cur_index[IDX_W-1:0]];
          cur_valid     = 1'b1;
          cur_index     = cur_index + 5'd1;
          loc_left      = loc_left - 5'd1;
          consume_table_entry();
          continue;
        end
        if (tot_left == 0) begin
          pending_bytes = '0;
          push_result(RES_NO_DESC, '0, '0, write_dir, '0, 1'b1);
          return;
        end
        awaiting_fetch = 1'b1;
        push_result(RES_FETCH, tbl_addr, 32'(DESC_BYTES), 1'b1, '0, 1'b1);
        return;
      end
      piece = (pending_bytes < cur_remaining) ? pending_bytes : cur_remaining;
      off = moved_bytes;
      moved_bytes = moved_bytes + piece;
      push_result(RES_SEG, cur_addr, piece, write_dir, off, 1'b0);
      cur_addr      = cur_addr + 64'(piece);
      cur_remaining = cur_remaining - piece;
      pending_bytes = pending_bytes - piece;
    end
    push_result(RES_DONE, '0, '0, write_dir, '0, 1'b1);
  endfunction

  function automatic void apply_request(req_t r);
    case (r.req_type)
      REQ_START: begin
        tbl_addr       = r.address;
        tot_left       = r.total_count;
        loc_left       = (r.local_count > LOCAL_DEPTH) ? 5'(LOCAL_DEPTH) : r.local_count;
        write_dir      = r.to_device;
        load_idx       = '0;
        cur_index      = '0;
        cur_valid      = 1'b0;
        cur_addr       = '0;
        cur_remaining  = '0;
        pending_bytes  = '0;
        moved_bytes    = '0;
        awaiting_fetch = 1'b0;
      end
      REQ_LOAD: begin
        if (load_idx < LOCAL_DEPTH) begin
          desc_addr[load_idx[IDX_W-1:0]] = r.address;
          desc_len[load_idx[IDX_W-1:0]]  = r.length;
          load_idx = load_idx + 5'd1;
        end
      end
      REQ_XFER: begin
        if (!awaiting_fetch) begin
          pending_bytes = r.length;
          moved_bytes   = '0;
          walk_pending();
        end
      end
      default: begin
        if (awaiting_fetch) begin
          awaiting_fetch = 1'b0;
          consume_table_entry();
          if (r.fetch_failed) begin
            pending_bytes = '0;
            cur_valid     = 1'b0;
            push_result(RES_FETCH_ERR, '0, '0, write_dir, '0, 1'b1);
          end else begin
            cur_addr      = r.address;
            cur_remaining = r.length;
            cur_valid     = 1'b1;
            walk_pending();
          end
        end
      end
    endcase
  endfunction

  function automatic void check_result(res_t got, res_t want);
    if (got.result_kind !== want.result_kind) begin
      $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
      fail_count++;
    end
    if (got.seg_address !== want.seg_address) begin
      $error("seg_address: expected %h, got %h", want.seg_address, got.seg_address);
      fail_count++;
    end
    if (got.seg_length !== want.seg_length) begin
      $error("seg_length: expected %h, got %h", want.seg_length, got.seg_length);
      fail_count++;
    end
    if (got.direction !== want.direction) begin
      $error("direction: expected %b, got %b", want.direction, got.direction);
      fail_count++;
    end
    if (got.buffer_offset !== want.buffer_offset) begin
      $error("buffer_offset: expected %h, got %h", want.buffer_offset, got.buffer_offset);
      fail_count++;
    end
    if (got.bytes_done !== want.bytes_done) begin
      $error("bytes_done: expected %h, got %h", want.bytes_done, got.bytes_done);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %b, got %b", want.last, got.last);
      fail_count++;
    end
  endfunction

  // results, acceptance, prediction and the stall watchdog, all on the rising edge
  always @(posedge clk_i) begin
    res_t want;
    took_item <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (res_strobe_o) begin
        if (walk_results_q.size() == 0) begin
          $error("result_kind: expected none, got %0d", res_o.result_kind);
          fail_count++;
        end else begin
          want = walk_results_q.pop_front();
          check_result(res_o, want);
        end
      end
      if (start && !busy) begin
        apply_request(req_drv);
        served_items++;
      end
      if (res_strobe_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // item driver: hold until taken, then next item or an idle cycle
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took_item)) begin
      if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        req_drv <= request_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(req_type_e kind, logic [63:0] addr, logic [31:0] len,
                            logic [15:0] tot, logic [4:0] loc, logic dir, logic fail);
    req_t r;
    r.req_type     = kind;
    r.address      = addr;
    r.length       = len;
    r.total_count  = tot;
    r.local_count  = loc;
    r.to_device    = dir;
    r.fetch_failed = fail;
    request_q.push_back(r);
  endtask

  function automatic req_t random_item(req_type_e kind);
    req_t r;
    r.req_type     = kind;
    r.address      = {$urandom, $urandom};
    r.length       = $urandom;
    r.total_count  = 16'($urandom);
    r.local_count  = 5'($urandom);
    r.to_device    = 1'($urandom);
    r.fetch_failed = 1'($urandom);
    return r;
  endfunction

  function automatic logic [31:0] pick_desc_len();
    case ($urandom_range(7))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(64, 1);
    endcase
  endfunction

  // one request: start, its locals, a few transfers each trailed by up to three fetch replies; or a lone random item
  task automatic queue_random_request();
    req_t r;
    int unsigned nloc;
    int unsigned nload;
    if ($urandom_range(99) < 12) begin
      request_q.push_back(random_item(req_type_e'($urandom_range(3))));
      return;
    end
    r = random_item(REQ_START);
    nloc = ($urandom_range(9) == 0) ? $urandom_range(31, 17) : $urandom_range(LOCAL_DEPTH);
    r.local_count = 5'(nloc);
    if ($urandom_range(7) != 0) r.total_count = 16'($urandom_range(nloc + 6));
    if ($urandom_range(9) == 0) r.address = 64'hFFFF_FFFF_FFFF_FF00 | $urandom_range(255);
    request_q.push_back(r);
    nload = ((nloc > LOCAL_DEPTH) ? LOCAL_DEPTH : nloc) + (($urandom_range(9) == 0) ? 2 : 0);
    repeat (nload) begin
      r = random_item(REQ_LOAD);
      r.length = pick_desc_len();
      request_q.push_back(r);
    end
    repeat ($urandom_range(3, 1)) begin
      r = random_item(REQ_XFER);
      case ($urandom_range(9))
        0: r.length = '0;
        1: ;
        default: r.length = $urandom_range(400, 1);
      endcase
      request_q.push_back(r);
      repeat ($urandom_range(3)) begin
        r = random_item(REQ_FETCH);
        r.length = pick_desc_len();
        r.fetch_failed = ($urandom_range(7) == 0);
        request_q.push_back(r);
      end
    end
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || start || walk_results_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned batch;
    int phase;

    // empty transfer straight out of reset, then a fetch nobody asked for
    queue_item(REQ_XFER, '0, '0, '0, '0, 1'b0, 1'b0);
    queue_item(REQ_FETCH, {$urandom, $urandom}, 32'h40, '0, '0, 1'b0, 1'b0);
    // local count above the store depth, table address about to wrap
    queue_item(REQ_START, 64'hFFFF_FFFF_FFFF_FF80, 32'h0, 16'hFFFF, 5'd31, 1'b1, 1'b0);
    for (int i = 0; i < LOCAL_DEPTH; i++) begin
      if (i == 0) queue_item(REQ_LOAD, '1, 32'd3, '0, '0, 1'b0, 1'b0);
      else if (i == 1) queue_item(REQ_LOAD, {$urandom, $urandom}, '0, '0, '0, 1'b0, 1'b0);
      else queue_item(REQ_LOAD, {$urandom, $urandom}, 32'(i * 4), '0, '0, 1'b0, 1'b0);
    end
    // store already full
    queue_item(REQ_LOAD, '0, 32'h1234, '1, '1, 1'b1, 1'b1);
    queue_item(REQ_XFER, '0, 32'd2, '0, '0, 1'b0, 1'b0);
    queue_item(REQ_XFER, '0, '1, '0, '0, 1'b0, 1'b0);
    // transfer while a fetch is outstanding
    queue_item(REQ_XFER, '0, 32'd9, '0, '0, 1'b0, 1'b0);
    queue_item(REQ_FETCH, 64'hFFFF_FFFF_FFFF_FFFE, '1, '0, '0, 1'b0, 1'b0);
    // external-only request: zero-length fetch, failed fetch, then out of entries
    queue_item(REQ_START, 64'h1000, '0, 16'd2, 5'd0, 1'b0, 1'b0);
    queue_item(REQ_XFER, '0, 32'd50, '0, '0, 1'b0, 1'b0);
    queue_item(REQ_FETCH, {$urandom, $urandom}, '0, '0, '0, 1'b0, 1'b0);
    queue_item(REQ_FETCH, {$urandom, $urandom}, 32'd80, '0, '0, 1'b0, 1'b1);
    queue_item(REQ_XFER, '0, 32'd10, '0, '0, 1'b0, 1'b0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    batch = 0;
    // items taken so far plus those still queued
    while (served_items + request_q.size() < ITEM_COUNT) begin
      if (batch % 5 == 0) begin
        // sender holds off until everything owed has come back
        wait_drained();
        phase = (batch / 5) % 3;
        idle_pct = (phase == 1) ? 61 : (phase == 2) ? 29 : 0;
      end
      queue_random_request();
      batch++;
      while (request_q.size() >= 4) @(negedge clk_i);
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
